FILE: hw/rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int RANK_LIMIT_DEF = 12;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int KIND_W      = 3;
    localparam int ADDR_W      = 64;
    localparam int RANK_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int ANSWER_W    = 12;
    localparam int PAGES_W     = 12;
    localparam int START_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
    localparam logic [PAGES_W-1:0] PAGES_RESET = 12'd2048;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT   = 3'd0,
        KIND_ALLOC  = 3'd1,
        KIND_FREE   = 3'd2,
        KIND_QRANK  = 3'd3,
        KIND_QCOUNT = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_PAGES = 2'd1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_INIT_SET, S_CLR, S_SEARCH, S_POP_RD, S_POP_WR, S_POP_WR2,
        S_SPLIT, S_PUSH2, S_ALLOC_WR, S_ADDR, S_FREE_RD, S_FREE_CHK, S_MRG, S_MRG2,
        S_MRG3, S_MRG4, S_QR_RD, S_QR_CHK, S_QR_LOOP, S_QR_LOOP2, S_QCOUNT, S_BAD,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_DECODE, OP_INIT_SET, OP_CLR, OP_SEARCH, OP_POP_RD, OP_POP_WR,
        OP_POP_WR2, OP_SPLIT, OP_PUSH2, OP_ALLOC_PG, OP_ALLOC_WR, OP_ADDR, OP_START_RD,
        OP_BAD, OP_FREE_CHK, OP_MRG, OP_UNLINK_RD, OP_UNLINK, OP_UNLINK2, OP_PUSH_N,
        OP_QR_HIT, OP_QR_SETUP, OP_PROBE_RD, OP_QR_END, OP_PROBE_STEP, OP_QCOUNT,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic rank_bad;
        logic i_gt_riu;
        logic head_zero;
        logic i_gt_rank;
        logic pg_ok;
        logic start_zero;
        logic r_lt_riu;
        logic taken_b;
        logic probe_more;
        logic clr_last;
    } t_stat;

endpackage

FILE: hw/rtl/bpa_ctrl.sv
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output bpa_pkg::t_cmd  o_cmd,
    input  bpa_pkg::t_stat i_stat
);
    import bpa_pkg::*;

    t_state r_state, n_state;
    logic   r_silent, n_silent;
    logic   r_ovalid, n_ovalid;
    t_op    w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT_SET;
            r_silent <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_silent <= n_silent;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_silent = r_silent;
        n_ovalid = r_ovalid && !i_m_tready;
        w_op     = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state  = S_DECODE;
                    n_silent = 1'b0;
                end
            end
            S_DECODE: begin
                w_op = OP_DECODE;
                case (i_stat.kind)
                    KIND_INIT:   n_state = S_INIT_SET;
                    KIND_ALLOC:  n_state = i_stat.rank_bad ? S_BAD : S_SEARCH;
                    KIND_FREE:   n_state = S_ADDR;
                    KIND_QRANK:  n_state = S_ADDR;
                    KIND_QCOUNT: n_state = i_stat.rank_bad ? S_BAD : S_QCOUNT;
                    default:     n_state = S_BAD;
                endcase
            end
            S_INIT_SET: begin
                w_op    = OP_INIT_SET;
                n_state = S_CLR;
            end
            S_CLR: begin
                w_op = OP_CLR;
                if (i_stat.clr_last) begin
                    n_state = r_silent ? S_IDLE : S_DONE;
                end
            end
            S_SEARCH: begin
                w_op = OP_SEARCH;
                if (i_stat.i_gt_riu) begin
                    n_state = S_DONE;
                end else if (!i_stat.head_zero) begin
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                w_op    = OP_POP_RD;
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                w_op    = OP_POP_WR;
                n_state = S_POP_WR2;
            end
            S_POP_WR2: begin
                w_op    = OP_POP_WR2;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_stat.i_gt_rank) begin
                    w_op    = OP_SPLIT;
                    n_state = S_PUSH2;
                end else begin
                    w_op    = OP_ALLOC_PG;
                    n_state = S_ALLOC_WR;
                end
            end
            S_PUSH2: begin
                w_op    = OP_PUSH2;
                n_state = (i_stat.kind == KIND_ALLOC) ? S_SPLIT : S_DONE;
            end
            S_ALLOC_WR: begin
                w_op    = OP_ALLOC_WR;
                n_state = S_DONE;
            end
            S_ADDR: begin
                w_op    = OP_ADDR;
                n_state = (i_stat.kind == KIND_FREE) ? S_FREE_RD : S_QR_RD;
            end
            S_FREE_RD: begin
                if (!i_stat.pg_ok) begin
                    w_op    = OP_BAD;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_START_RD;
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (i_stat.start_zero) begin
                    w_op    = OP_BAD;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_FREE_CHK;
                    n_state = S_MRG;
                end
            end
            S_MRG: begin
                if (i_stat.r_lt_riu) begin
                    w_op    = OP_MRG;
                    n_state = S_MRG2;
                end else begin
                    w_op    = OP_PUSH_N;
                    n_state = S_PUSH2;
                end
            end
            S_MRG2: begin
                // A taken buddy ends the merge walk.
                if (i_stat.taken_b) begin
                    w_op    = OP_PUSH_N;
                    n_state = S_PUSH2;
                end else begin
                    w_op    = OP_UNLINK_RD;
                    n_state = S_MRG3;
                end
            end
            S_MRG3: begin
                w_op    = OP_UNLINK;
                n_state = S_MRG4;
            end
            S_MRG4: begin
                w_op    = OP_UNLINK2;
                n_state = S_MRG;
            end
            S_QR_RD: begin
                if (!i_stat.pg_ok) begin
                    w_op    = OP_BAD;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_START_RD;
                    n_state = S_QR_CHK;
                end
            end
            S_QR_CHK: begin
                if (!i_stat.start_zero) begin
                    w_op    = OP_QR_HIT;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_QR_SETUP;
                    n_state = S_QR_LOOP;
                end
            end
            S_QR_LOOP: begin
                if (i_stat.probe_more) begin
                    w_op    = OP_PROBE_RD;
                    n_state = S_QR_LOOP2;
                end else begin
                    w_op    = OP_QR_END;
                    n_state = S_DONE;
                end
            end
            S_QR_LOOP2: begin
                if (!i_stat.start_zero) begin
                    w_op    = OP_QR_END;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_PROBE_STEP;
                    n_state = S_QR_LOOP;
                end
            end
            S_QCOUNT: begin
                w_op    = OP_QCOUNT;
                n_state = S_DONE;
            end
            S_BAD: begin
                w_op    = OP_BAD;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    w_op     = OP_DONE;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_cmd.op   = w_op;
    assign o_cmd.load = (r_state == S_IDLE) && i_s_tvalid;

endmodule

FILE: hw/rtl/bpa_dpath.sv
module bpa_dpath #(
    parameter int RANK_LIMIT = bpa_pkg::RANK_LIMIT_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpa_pkg::t_cmd                  i_cmd,
    output bpa_pkg::t_stat                 o_stat,
    input  logic [bpa_pkg::KIND_W-1:0]     i_kind,
    input  logic [bpa_pkg::ADDR_W-1:0]     i_block_address,
    input  logic [bpa_pkg::RANK_W-1:0]     i_block_rank,
    input  logic                           i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]     i_cfg_data,
    output logic [bpa_pkg::STATUS_W-1:0]   o_status,
    output logic [bpa_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [bpa_pkg::ANSWER_W-1:0]   o_answer_value
);
    import bpa_pkg::*;

    localparam int NW = RANK_LIMIT;
    localparam int PW = RANK_LIMIT - 1;
    localparam int CW = RANK_LIMIT + 1;
    localparam int RW = $clog2(RANK_LIMIT + 2);
    localparam int IW = $clog2(RANK_LIMIT);
    localparam int QW = PW + 2;
    localparam int NODE_COUNT = 1 << NW;
    localparam int PAGE_CAP = 1 << PW;
    localparam logic [CW-1:0] CNT_MAX = CW'(NODE_COUNT);

    // Configuration, latched into the working state at init.
    logic [ADDR_W-1:0]  r_cfg_base;
    logic [PAGES_W-1:0] r_cfg_pages;

    logic [KIND_W-1:0]  r_kind;
    logic [ADDR_W-1:0]  r_addr;
    logic [RANK_W-1:0]  r_rank;
    logic [RW-1:0]      r_riu;
    logic [ADDR_W-1:0]  r_base;
    logic [RW-1:0]      r_i;
    logic [NW-1:0]      r_n, r_b, r_nx;
    logic [PW-1:0]      r_p;
    logic               r_pg_ok;
    logic [QW-1:0]      r_pi, r_end;
    logic [NW-1:0]      r_clr;
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]  r_granted;
    logic [ANSWER_W-1:0] r_answer;
    logic [NW-1:0]      r_head [RANK_LIMIT];
    logic [CW-1:0]      r_cnt  [RANK_LIMIT];

    logic               r_taken_mem [NODE_COUNT];
    logic [NW-1:0]      r_next_mem  [NODE_COUNT];
    logic [NW-1:0]      r_prev_mem  [NODE_COUNT];
    logic [START_W-1:0] r_start_mem [PAGE_CAP];
    logic               r_q_taken;
    logic [NW-1:0]      r_q_next, r_q_prev;
    logic [START_W-1:0] r_q_start;

    logic               w_tk_we, w_tk_wd;
    logic [NW-1:0]      w_tk_wa, w_tk_ra;
    logic               w_nx_we, w_pv_we, w_st_we;
    logic [NW-1:0]      w_nx_wa, w_nx_wd, w_nx_ra, w_pv_wa, w_pv_wd;
    logic [PW-1:0]      w_st_wa, w_st_ra;
    logic [START_W-1:0] w_st_wd;

    logic [IW-1:0]      w_hidx;
    logic [NW-1:0]      w_head_rd;
    logic [CW-1:0]      w_cnt_rd;
    logic [RW-1:0]      w_riu_new;
    logic [31:0]        w_pages;
    logic               w_rank_bad;
    logic [NW-1:0]      w_child_r, w_child_l;
    logic [64:0]        w_diff;
    logic [PW:0]        w_lim;
    logic [RW-1:0]      w_depth;
    logic [NW-1:0]      w_off, w_free_n;
    logic [PW:0]        w_qv, w_qlow;
    logic [QW-1:0]      w_pi_low;

    always_comb begin
        w_pages   = (r_cfg_pages == '0) ? 32'd1 : 32'(r_cfg_pages);
        w_riu_new = '0;
        for (int k = 0; k < RANK_LIMIT; k++) begin
            if ((32'd1 << k) <= w_pages) begin
                w_riu_new = w_riu_new + RW'(1);
            end
        end
    end

    assign w_rank_bad = (r_rank == '0) || (32'(r_rank) > RANK_LIMIT);
    assign w_child_l  = {r_n[NW-2:0], 1'b0};
    assign w_child_r  = {r_n[NW-2:0], 1'b1};

    // Page lookup: below base, beyond the managed area or inside it.
    assign w_diff = {1'b0, r_addr} - {1'b0, r_base};
    assign w_lim  = (PW+1)'(1) << (r_riu - RW'(1));

    assign w_depth  = r_riu - RW'(r_rank);
    assign w_off    = r_n - (NW'(1) << w_depth);
    assign w_free_n = (NW'((PW+1)'(1) << (r_riu - RW'(1))) + NW'(r_p))
                      >> (r_q_start - START_W'(1));
    assign w_qv     = w_lim | {1'b0, r_p};
    assign w_qlow   = w_qv & (~w_qv + (PW+1)'(1));
    assign w_pi_low = r_pi & (~r_pi + QW'(1));

    always_comb begin
        case (i_cmd.op)
            OP_SPLIT:  w_hidx = IW'(r_i - RW'(2));
            OP_QCOUNT: w_hidx = IW'(r_rank - RANK_W'(1));
            default:   w_hidx = IW'(r_i - RW'(1));
        endcase
    end
    assign w_head_rd = r_head[w_hidx];
    assign w_cnt_rd  = r_cnt[w_hidx];

    // Memory write and read ports, one action per command.
    always_comb begin
        w_tk_we = 1'b0;  w_tk_wa = r_n;  w_tk_wd = 1'b0;
        w_nx_we = 1'b0;  w_nx_wa = r_n;  w_nx_wd = '0;
        w_pv_we = 1'b0;  w_pv_wa = r_n;  w_pv_wd = '0;
        w_st_we = 1'b0;  w_st_wa = r_p;  w_st_wd = '0;
        w_tk_ra = r_n ^ NW'(1);
        w_nx_ra = (i_cmd.op == OP_POP_RD) ? r_n : r_b;
        w_st_ra = (i_cmd.op == OP_PROBE_RD) ? r_pi[PW-1:0] : r_p;
        case (i_cmd.op)
            OP_CLR: begin
                w_tk_we = 1'b1;  w_tk_wa = r_clr;
                w_nx_we = 1'b1;  w_nx_wa = r_clr;
                w_pv_we = 1'b1;  w_pv_wa = r_clr;
                w_st_we = 1'b1;  w_st_wa = r_clr[PW-1:0];
            end
            OP_POP_WR: begin
                w_nx_we = 1'b1;
                w_pv_we = (r_q_next != '0);
                w_pv_wa = r_q_next;
            end
            OP_POP_WR2: w_pv_we = 1'b1;
            OP_SPLIT: begin
                w_tk_we = 1'b1;  w_tk_wd = 1'b1;
                w_nx_we = 1'b1;  w_nx_wa = w_child_r;  w_nx_wd = w_head_rd;
                w_pv_we = 1'b1;  w_pv_wa = w_child_r;
            end
            OP_PUSH2: begin
                w_pv_we = (r_nx != '0);  w_pv_wa = r_nx;  w_pv_wd = r_b;
            end
            OP_ALLOC_PG: begin
                w_tk_we = 1'b1;  w_tk_wd = 1'b1;
            end
            OP_ALLOC_WR: begin
                w_st_we = 1'b1;  w_st_wd = START_W'(r_rank);
            end
            OP_FREE_CHK: w_st_we = 1'b1;
            OP_MRG:      w_tk_we = 1'b1;
            OP_UNLINK: begin
                w_nx_we = (r_q_prev != '0);  w_nx_wa = r_q_prev;  w_nx_wd = r_q_next;
                w_pv_we = (r_q_next != '0);  w_pv_wa = r_q_next;  w_pv_wd = r_q_prev;
            end
            OP_UNLINK2: begin
                w_nx_we = 1'b1;  w_nx_wa = r_b;
                w_pv_we = 1'b1;  w_pv_wa = r_b;
            end
            OP_PUSH_N: begin
                w_tk_we = 1'b1;
                w_nx_we = 1'b1;  w_nx_wd = w_head_rd;
                w_pv_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tk_we) r_taken_mem[w_tk_wa] <= w_tk_wd;
        r_q_taken <= r_taken_mem[w_tk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_nx_we) r_next_mem[w_nx_wa] <= w_nx_wd;
        r_q_next <= r_next_mem[w_nx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_pv_we) r_prev_mem[w_pv_wa] <= w_pv_wd;
        r_q_prev <= r_prev_mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) r_start_mem[w_st_wa] <= w_st_wd;
        r_q_start <= r_start_mem[w_st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= BASE_RESET;
            r_cfg_pages <= PAGES_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BASE) begin
                r_cfg_base <= i_cfg_data;
            end else if (i_cfg_index == CFG_PAGES) begin
                r_cfg_pages <= i_cfg_data[PAGES_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_addr <= i_block_address;
            r_rank <= i_block_rank;
        end
        case (i_cmd.op)
            OP_DECODE: begin
                r_status  <= ST_OK;
                r_granted <= '0;
                r_answer  <= '0;
                r_i       <= RW'(r_rank);
            end
            OP_INIT_SET: begin
                r_riu  <= w_riu_new;
                r_base <= r_cfg_base;
                r_clr  <= '0;
                // Only the top usable rank starts with a free block.
                for (int k = 0; k < RANK_LIMIT; k++) begin
                    r_head[k] <= (RW'(k + 1) == w_riu_new) ? NW'(1) : '0;
                    r_cnt[k]  <= (RW'(k + 1) == w_riu_new) ? CW'(1) : '0;
                end
            end
            OP_CLR: r_clr <= r_clr + NW'(1);
            OP_SEARCH: begin
                if (r_i > r_riu) begin
                    r_status <= ST_NO_SPACE;
                end else if (w_head_rd == '0) begin
                    r_i <= r_i + RW'(1);
                end else begin
                    r_n <= w_head_rd;
                end
            end
            OP_POP_WR: begin
                r_head[w_hidx] <= r_q_next;
                if (w_cnt_rd != '0) r_cnt[w_hidx] <= w_cnt_rd - CW'(1);
            end
            OP_SPLIT: begin
                r_b  <= w_child_r;
                r_nx <= w_head_rd;
                r_i  <= r_i - RW'(1);
                r_n  <= w_child_l;
            end
            OP_PUSH2: begin
                r_head[w_hidx] <= r_b;
                if (w_cnt_rd < CNT_MAX) r_cnt[w_hidx] <= w_cnt_rd + CW'(1);
            end
            OP_ALLOC_PG: r_p <= PW'(w_off << (r_rank - RANK_W'(1)));
            OP_ALLOC_WR: r_granted <= r_base + (ADDR_W'(r_p) << PAGE_SHIFT);
            OP_ADDR: begin
                r_p     <= w_diff[PAGE_SHIFT +: PW];
                r_pg_ok <= !w_diff[64] && ((w_diff[63:0] >> (PAGE_SHIFT + PW)) == '0)
                           && ({1'b0, w_diff[PAGE_SHIFT +: PW]} < w_lim);
            end
            OP_BAD: r_status <= ST_INVALID;
            OP_FREE_CHK: begin
                r_i <= RW'(r_q_start);
                r_n <= w_free_n;
            end
            OP_MRG: r_b <= r_n ^ NW'(1);
            OP_UNLINK: begin
                if (r_q_prev == '0) r_head[w_hidx] <= r_q_next;
            end
            OP_UNLINK2: begin
                if (w_cnt_rd != '0) r_cnt[w_hidx] <= w_cnt_rd - CW'(1);
                r_n <= r_n >> 1;
                r_i <= r_i + RW'(1);
            end
            OP_PUSH_N: begin
                r_b  <= r_n;
                r_nx <= w_head_rd;
            end
            OP_QR_HIT: r_answer <= ANSWER_W'(r_q_start);
            OP_QR_SETUP: begin
                r_i   <= RW'(1);
                r_pi  <= QW'(r_p) + QW'(1);
                r_end <= QW'(r_p) + QW'(w_qlow);
            end
            OP_PROBE_STEP: begin
                r_i  <= r_i + RW'(1);
                r_pi <= r_pi + w_pi_low;
            end
            OP_QR_END: r_answer <= ANSWER_W'(r_i);
            OP_QCOUNT: r_answer <= ANSWER_W'(w_cnt_rd);
            OP_DONE: begin
                o_status          <= r_status;
                o_granted_address <= r_granted;
                o_answer_value    <= r_answer;
            end
            default: ;
        endcase
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.rank_bad   = w_rank_bad;
    assign o_stat.i_gt_riu   = (r_i > r_riu);
    assign o_stat.head_zero  = (w_head_rd == '0);
    assign o_stat.i_gt_rank  = (32'(r_i) > 32'(r_rank));
    assign o_stat.pg_ok      = r_pg_ok;
    assign o_stat.start_zero = (r_q_start == '0);
    assign o_stat.r_lt_riu   = (r_i < r_riu);
    assign o_stat.taken_b    = r_q_taken;
    assign o_stat.probe_more = (r_pi < r_end);
    assign o_stat.clr_last   = (r_clr == {NW{1'b1}});

endmodule

FILE: hw/rtl/buddy_page_allocator_core.sv
// Init runs a clearing pass over the node tables. Alloc skips empty ranks upward,
// pops a block and splits it down to the asked rank; free merges the block with
// its free buddies; query rank probes pages upward; query count reads a count.
// One word is worked on at a time; the result sits in an output register.
// Reset (synchronous, active low) restores the register defaults and runs the
// same clearing pass, with s_tready low and no result.
module buddy_page_allocator_core #(
    parameter int RANK_LIMIT = bpa_pkg::RANK_LIMIT_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // block_address [63:0], block_rank [67:64], zero pad [71:68]
    input  logic [bpa_pkg::IN_TDATA_W-1:0]    s_tdata,
    // kind [2:0]
    input  logic [bpa_pkg::KIND_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], granted_address [65:2], answer_value [77:66], zero pad [79:78]
    output logic [bpa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]        i_cfg_data
);
    import bpa_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [STATUS_W-1:0] w_status;
    logic [ADDR_W-1:0]   w_granted;
    logic [ANSWER_W-1:0] w_answer;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    bpa_dpath #(
        .RANK_LIMIT (RANK_LIMIT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_kind            (s_tuser),
        .i_block_address   (s_tdata[63:0]),
        .i_block_rank      (s_tdata[67:64]),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (w_status),
        .o_granted_address (w_granted),
        .o_answer_value    (w_answer)
    );

    assign m_tdata = {2'b00, w_answer, w_granted, w_status};

endmodule

FILE: hw/rtl/bpa_checker.sv
module bpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bpa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bpa_pkg::*;

    // A result word waits until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // Only a successful alloc carries an address.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[65:2] == '0)
        else $error("address granted with a failing status");

    a_grant_no_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[65:2] != '0 |-> m_tdata[77:66] == '0)
        else $error("granted address and answer value both set");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
